// ----- rtl/sha1md_pkg.sv -----
// Shared types, constants and helpers for the SHA-1 message digest block.
package sha1md_pkg;

  localparam int unsigned NumWords   = 5;
  localparam int unsigned NumRounds  = 80;
  localparam int unsigned BlockBytes = 64;
  localparam int unsigned LenBytes   = 8;

  localparam logic [1:0] OP_ABSORB        = 2'd0;
  localparam logic [1:0] OP_ABSORB_FINISH = 2'd1;
  localparam logic [1:0] OP_FINISH        = 2'd2;

  localparam logic [7:0] PAD_MARKER = 8'h80;

  localparam logic [31:0] K0 = 32'h5a827999;
  localparam logic [31:0] K1 = 32'h6ed9eba1;
  localparam logic [31:0] K2 = 32'h8f1bbcdc;
  localparam logic [31:0] K3 = 32'hca62c1d6;

  localparam logic [31:0] H_INIT [NumWords] = '{
    32'h67452301, 32'hefcdab89, 32'h98badcfe, 32'h10325476, 32'hc3d2e1f0
  };

  // One word on the input side.
  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] data_byte;
  } in_word_t;

  // One word on the output side.
  typedef struct packed {
    logic [31:0] digest_word;
    logic [2:0]  word_index;
    logic        last_word;
  } out_word_t;

  // Working variables of the compression.
  typedef struct packed {
    logic [31:0] a;
    logic [31:0] b;
    logic [31:0] c;
    logic [31:0] d;
    logic [31:0] e;
  } work_t;

  // Control from the sequencer to the block buffer / schedule window.
  typedef struct packed {
    logic       byte_en;
    logic       word_en;
    logic [7:0] byte_val;
  } sched_ctrl_t;

  function automatic logic [31:0] rotl32(input logic [31:0] x, input int unsigned s);
    rotl32 = (x << s) | (x >> (32 - s));
  endfunction

endpackage

// ----- rtl/sha1md_sched.sv -----
// Block buffer that doubles as the 16-word sliding message schedule window.
module sha1md_sched (
  input  logic                    clk_i,
  input  sha1md_pkg::sched_ctrl_t ctrl_i,
  output logic [31:0]             w_o
);
  import sha1md_pkg::*;

  logic [511:0] blk_q, blk_d;
  logic [31:0]  w_new;

  // Word j of the window sits at the top for j = 0; t+13, t+8, t+2, t.
  assign w_new = rotl32(blk_q[511-32*13 -: 32] ^ blk_q[511-32*8 -: 32] ^
                        blk_q[511-32*2 -: 32] ^ blk_q[511 -: 32], 1);

  always_comb begin
    blk_d = blk_q;
    if (ctrl_i.byte_en) begin
      blk_d = {blk_q[503:0], ctrl_i.byte_val};
    end else if (ctrl_i.word_en) begin
      blk_d = {blk_q[479:0], w_new};
    end
  end

  always_ff @(posedge clk_i) begin
    blk_q <= blk_d;
  end

  assign w_o = blk_q[511 -: 32];

endmodule

// ----- rtl/sha1md_round.sv -----
// One SHA-1 round: selects f and K by round number and forms the next a..e.
module sha1md_round (
  input  sha1md_pkg::work_t v_i,
  input  logic [31:0]       w_i,
  input  logic [6:0]        rnd_i,
  output sha1md_pkg::work_t v_o
);
  import sha1md_pkg::*;

  logic [31:0] f, k;

  always_comb begin
    if (rnd_i < 7'd20) begin
      f = (v_i.b & v_i.c) | (~v_i.b & v_i.d);
      k = K0;
    end else if (rnd_i < 7'd40) begin
      f = v_i.b ^ v_i.c ^ v_i.d;
      k = K1;
    end else if (rnd_i < 7'd60) begin
      f = (v_i.b & v_i.c) | (v_i.b & v_i.d) | (v_i.c & v_i.d);
      k = K2;
    end else begin
      f = v_i.b ^ v_i.c ^ v_i.d;
      k = K3;
    end
  end

  always_comb begin
    v_o.a = rotl32(v_i.a, 5) + f + v_i.e + k + w_i;
    v_o.b = v_i.a;
    v_o.c = rotl32(v_i.b, 30);
    v_o.d = v_i.c;
    v_o.e = v_i.d;
  end

endmodule

// ----- rtl/sha1_message_digest.sv -----
// Top level of the SHA-1 message digest block: byte intake, padding sequencer, rounds.
//
// The block hashes a message fed one byte per word. The byte that completes
// a 64-byte block starts a compression: 80 rounds, one round per cycle on a
// single shared round unit, then a fold of the working variables into the
// chaining words. A finish word then walks the padding one byte per cycle:
// the 0x80 marker, zeros up to byte 56 (through a second compression when the
// marker lands past byte 55), the eight length bytes, and a last compression,
// before the five digest words appear, H0 first, one per accepted output
// handshake. in_ready_o is high only while the block sits idle, and once the
// fifth word is taken the chaining words, byte count and bit count return to
// their initial values for the next message. Opcode 3 is accepted and dropped.
module sha1_message_digest (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  in_valid_i,
  output logic                  in_ready_o,
  input  sha1md_pkg::in_word_t  in_data_i,
  output logic                  out_valid_o,
  input  logic                  out_ready_i,
  output sha1md_pkg::out_word_t out_data_o
);
  import sha1md_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;  // waiting for a word
  localparam logic [2:0] S_PAD  = 3'd1;  // write the 0x80 marker
  localparam logic [2:0] S_ZERO = 3'd2;  // zero fill up to byte 56
  localparam logic [2:0] S_LEN  = 3'd3;  // big-endian bit length
  localparam logic [2:0] S_RND  = 3'd4;  // 80 rounds
  localparam logic [2:0] S_FIN  = 3'd5;  // fold into chaining words
  localparam logic [2:0] S_OUT  = 3'd6;  // hand out digest words

  logic [2:0]  state_q, state_d;
  logic [2:0]  ret_q, ret_d;      // where to go after a compression
  logic [6:0]  rnd_q, rnd_d;
  logic [5:0]  fill_q, fill_d;
  logic [63:0] cnt_q, cnt_d;
  logic [2:0]  lc_q, lc_d;        // length byte counter
  logic [2:0]  idx_q, idx_d;      // output word index
  logic [31:0] h_q [NumWords];
  logic [31:0] h_d [NumWords];
  work_t       v_q, v_d, v_rnd, h_work;

  sched_ctrl_t sctrl;
  logic [31:0] w_cur;
  logic        in_acc, out_acc;

  assign in_acc  = in_valid_i && in_ready_o;
  assign out_acc = out_valid_o && out_ready_i;

  assign h_work = '{a: h_q[0], b: h_q[1], c: h_q[2], d: h_q[3], e: h_q[4]};

  sha1md_sched u_sched (
    .clk_i  (clk_i),
    .ctrl_i (sctrl),
    .w_o    (w_cur)
  );

  sha1md_round u_round (
    .v_i   (v_q),
    .w_i   (w_cur),
    .rnd_i (rnd_q),
    .v_o   (v_rnd)
  );

  always_comb begin
    state_d = state_q;
    ret_d   = ret_q;
    rnd_d   = rnd_q;
    fill_d  = fill_q;
    cnt_d   = cnt_q;
    lc_d    = lc_q;
    idx_d   = idx_q;
    v_d     = v_q;
    h_d     = h_q;
    sctrl   = '{byte_en: 1'b0, word_en: 1'b0, byte_val: 8'h00};

    case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          case (in_data_i.opcode)
            OP_ABSORB, OP_ABSORB_FINISH: begin
              sctrl.byte_en  = 1'b1;
              sctrl.byte_val = in_data_i.data_byte;
              fill_d         = fill_q + 6'd1;
              cnt_d          = cnt_q + 64'd8;
              if (fill_q == 6'(BlockBytes - 1)) begin
                // block full: compress, then resume
                state_d = S_RND;
                ret_d   = (in_data_i.opcode == OP_ABSORB_FINISH) ? S_PAD : S_IDLE;
                rnd_d   = '0;
                v_d     = h_work;
              end else if (in_data_i.opcode == OP_ABSORB_FINISH) begin
                state_d = S_PAD;
              end
            end
            OP_FINISH: begin
              state_d = S_PAD;
            end
            default: begin
            end
          endcase
        end
      end
      S_PAD: begin
        sctrl.byte_en  = 1'b1;
        sctrl.byte_val = PAD_MARKER;
        fill_d         = fill_q + 6'd1;
        state_d        = S_ZERO;
        if (fill_q == 6'(BlockBytes - 1)) begin
          state_d = S_RND;
          ret_d   = S_ZERO;
          rnd_d   = '0;
          v_d     = h_work;
        end
      end
      S_ZERO: begin
        if (fill_q == 6'(BlockBytes - LenBytes)) begin
          state_d = S_LEN;
          lc_d    = '0;
        end else begin
          sctrl.byte_en = 1'b1;
          fill_d        = fill_q + 6'd1;
          if (fill_q == 6'(BlockBytes - 1)) begin
            // marker landed late: flush this block, then zero fill again
            state_d = S_RND;
            ret_d   = S_ZERO;
            rnd_d   = '0;
            v_d     = h_work;
          end
        end
      end
      S_LEN: begin
        sctrl.byte_en  = 1'b1;
        sctrl.byte_val = cnt_q[{~lc_q, 3'b000} +: 8];
        lc_d           = lc_q + 3'd1;
        fill_d         = fill_q + 6'd1;
        if (lc_q == 3'(LenBytes - 1)) begin
          state_d = S_RND;
          ret_d   = S_OUT;
          rnd_d   = '0;
          v_d     = h_work;
          idx_d   = '0;
        end
      end
      S_RND: begin
        sctrl.word_en = 1'b1;
        v_d           = v_rnd;
        rnd_d         = rnd_q + 7'd1;
        if (rnd_q == 7'(NumRounds - 1)) begin
          state_d = S_FIN;
        end
      end
      S_FIN: begin
        h_d[0]  = h_q[0] + v_q.a;
        h_d[1]  = h_q[1] + v_q.b;
        h_d[2]  = h_q[2] + v_q.c;
        h_d[3]  = h_q[3] + v_q.d;
        h_d[4]  = h_q[4] + v_q.e;
        state_d = ret_q;
      end
      S_OUT: begin
        if (out_acc) begin
          idx_d = idx_q + 3'd1;
          if (idx_q == 3'(NumWords - 1)) begin
            // message done: back to the initial values
            state_d = S_IDLE;
            h_d     = H_INIT;
            fill_d  = '0;
            cnt_d   = '0;
          end
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ret_q   <= S_IDLE;
      rnd_q   <= '0;
      fill_q  <= '0;
      cnt_q   <= '0;
      lc_q    <= '0;
      idx_q   <= '0;
      h_q     <= H_INIT;
    end else begin
      state_q <= state_d;
      ret_q   <= ret_d;
      rnd_q   <= rnd_d;
      fill_q  <= fill_d;
      cnt_q   <= cnt_d;
      lc_q    <= lc_d;
      idx_q   <= idx_d;
      h_q     <= h_d;
    end
  end

  // working variables are payload only
  always_ff @(posedge clk_i) begin
    v_q <= v_d;
  end

  assign in_ready_o  = (state_q == S_IDLE);
  assign out_valid_o = (state_q == S_OUT);

  assign out_data_o.digest_word = (idx_q < 3'(NumWords)) ? h_q[idx_q] : '0;
  assign out_data_o.word_index  = idx_q;
  assign out_data_o.last_word   = (idx_q == 3'(NumWords - 1));

  // never taking input while a digest is pending
  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(in_ready_o && out_valid_o))
    else $error("input ready while digest words pending");

  // the round counter never runs past the last round
  a_rnd_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RND) |-> (rnd_q < 7'(NumRounds)))
    else $error("round counter out of range");

  // taking the last digest word returns the block to idle
  a_last_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_acc && out_data_o.last_word) |=> in_ready_o)
    else $error("block not idle after last digest word");

  // only index 4 carries the last flag
  a_last_idx: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.last_word == (out_data_o.word_index == 3'd4)))
    else $error("last_word does not match word_index");

endmodule

// ----- tb/sha1_message_digest_test.sv -----
// Self-checking testbench for the SHA-1 message digest block.
`timescale 1ns / 1ps

module sha1_message_digest_test;
  import sha1md_pkg::*;

  // Opcode 3 has no meaning; the block takes it and drops it.
  localparam logic [1:0] OP_UNUSED = 2'd3;

  // Receiver stall length for the backpressure test, in cycles.
  localparam int unsigned HOLD_CYCLES = 400;

  // Quiet time after the last digest word; longer than a two-block finish.
  localparam int unsigned TAIL_CYCLES = 300;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_ready;
  in_word_t  in_data = '0;
  logic      out_valid;
  logic      out_ready = 1'b0;
  out_word_t out_data;

  sha1_message_digest u_top (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .in_valid_i (in_valid),
    .in_ready_o (in_ready),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_ready_i(out_ready),
    .out_data_o (out_data)
  );

  always #6 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Digest predictor: a software SHA-1 that tracks the block word by word.
  // State mirrors the block: chaining words, the 64-byte block, the fill and
  // the 64-bit message length in bits.
  // ---------------------------------------------------------------------------
  logic [31:0] hash_state [NumWords];
  logic [7:0]  msg_block [BlockBytes];
  int unsigned block_fill;
  logic [63:0] msg_bits;

  // Digest words still owed by the block, oldest first.
  out_word_t   digest_q [$];

  // Test control, shared between the stimulus and the two handshake processes.
  bit          sender_gaps = 1'b1;
  bit          receiver_stalls = 1'b1;
  int unsigned hold_cycles = 0;
  int unsigned words_sent = 0;
  int unsigned digests_owed = 0;
  int unsigned err_count = 0;

  function automatic logic [31:0] rol(input logic [31:0] x, input int unsigned n);
    return (x << n) | (x >> (32 - n));
  endfunction

  function automatic void hash_reset();
    for (int i = 0; i < NumWords; i++) hash_state[i] = H_INIT[i];
    block_fill = 0;
    msg_bits   = '0;
  endfunction

  // 80-round compression of msg_block into hash_state.
  function automatic void compress_block();
    logic [31:0] w [80];
    logic [31:0] a, b, c, d, e, f, k, nxt;
    for (int t = 0; t < 16; t++)
      w[t] = {msg_block[4*t], msg_block[4*t+1], msg_block[4*t+2], msg_block[4*t+3]};
    for (int t = 16; t < 80; t++)
      w[t] = rol(w[t-3] ^ w[t-8] ^ w[t-14] ^ w[t-16], 1);
    a = hash_state[0];
    b = hash_state[1];
    c = hash_state[2];
    d = hash_state[3];
    e = hash_state[4];
    for (int t = 0; t < 80; t++) begin
      if (t < 20) begin
        f = (b & c) | (~b & d);
        k = K0;
      end else if (t < 40) begin
        f = b ^ c ^ d;
        k = K1;
      end else if (t < 60) begin
        f = (b & c) | (b & d) | (c & d);
        k = K2;
      end else begin
        f = b ^ c ^ d;
        k = K3;
      end
      nxt = rol(a, 5) + f + e + k + w[t];
      e = d;
      d = c;
      c = rol(b, 30);
      b = a;
      a = nxt;
    end
    hash_state[0] += a;
    hash_state[1] += b;
    hash_state[2] += c;
    hash_state[3] += d;
    hash_state[4] += e;
  endfunction

  function automatic void absorb_byte(input logic [7:0] b);
    msg_block[block_fill] = b;
    block_fill++;
    msg_bits += 64'd8;
    if (block_fill == BlockBytes) begin
      compress_block();
      block_fill = 0;
    end
  endfunction

  // Pad, compress one or two final blocks and queue the five digest words.
  function automatic void finish_digest();
    int unsigned pos;
    out_word_t   w;
    pos = block_fill;
    msg_block[pos] = PAD_MARKER;
    pos++;
    // Marker past byte 55: no room for the length, so an extra block goes out.
    if (pos > BlockBytes - LenBytes) begin
      while (pos < BlockBytes) msg_block[pos++] = 8'h00;
      compress_block();
      pos = 0;
    end
    while (pos < BlockBytes - LenBytes) msg_block[pos++] = 8'h00;
    for (int i = 0; i < LenBytes; i++)
      msg_block[BlockBytes - 1 - i] = msg_bits[8*i +: 8];
    compress_block();
    for (int i = 0; i < NumWords; i++) begin
      w.digest_word = hash_state[i];
      w.word_index  = 3'(i);
      w.last_word   = (i == NumWords - 1);
      digest_q.push_back(w);
    end
    hash_reset();
  endfunction

  // Called once per accepted input word.
  function automatic void predict_word(input logic [1:0] op, input logic [7:0] b);
    if (op == OP_ABSORB || op == OP_ABSORB_FINISH) absorb_byte(b);
    if (op == OP_ABSORB_FINISH || op == OP_FINISH) begin
      finish_digest();
      digests_owed++;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Sender side. Inputs move on the falling edge; acceptance is seen on the
  // rising edge. Valid drops between words only in random gaps (sender_gaps).
  // ---------------------------------------------------------------------------
  task automatic send_word(input logic [1:0] op, input logic [7:0] b);
    in_word_t w;
    w.opcode    = op;
    w.data_byte = b;
    @(negedge clk);
    while (sender_gaps && $urandom_range(99) < 17) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_word(op, b);
    if (op != OP_UNUSED) words_sent++;
  endtask

  // Drop valid and wait for every owed digest word to come out.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (digest_q.size() != 0) @(posedge clk);
  endtask

  // One message of len random bytes, then a finish. Either the last byte
  // rides on the finish word or a bare finish follows; an empty message
  // always uses the bare finish.
  task automatic send_message(input int unsigned len, input bit fused, input bit noise);
    for (int unsigned i = 0; i < len; i++) begin
      if (noise && $urandom_range(99) < 5) send_word(OP_UNUSED, 8'($urandom));
      if (fused && i == len - 1) send_word(OP_ABSORB_FINISH, 8'($urandom));
      else                       send_word(OP_ABSORB, 8'($urandom));
    end
    if (!fused || len == 0) send_word(OP_FINISH, 8'($urandom));
  endtask

  // ---------------------------------------------------------------------------
  // Receiver side: random stalls, or a counted hold-off when a test asks.
  // ---------------------------------------------------------------------------
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_ready <= 1'b0;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_ready <= !receiver_stalls || ($urandom_range(99) >= 17);
    end
  end

  function automatic void report_mismatch(input string what, input logic [31:0] want,
                                          input logic [31:0] got);
    err_count++;
    if (err_count <= 10)
      $display("%0t: digest %s mismatch: expected %h, got %h", $realtime, what, want, got);
  endfunction

  // Every accepted digest word is checked against the oldest prediction.
  always @(posedge clk) begin : check_digest
    out_word_t want;
    if (rst_n && out_valid && out_ready) begin
      if (digest_q.size() == 0) begin
        report_mismatch("word (none owed)", 32'h0, out_data.digest_word);
      end else begin
        want = digest_q.pop_front();
        if (out_data.digest_word !== want.digest_word)
          report_mismatch("value", want.digest_word, out_data.digest_word);
        if (out_data.word_index !== want.word_index)
          report_mismatch("index", 32'(want.word_index), 32'(out_data.word_index));
        if (out_data.last_word !== want.last_word)
          report_mismatch("last flag", 32'(want.last_word), 32'(out_data.last_word));
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Empty message, "abc", byte extremes, the unused opcode and a bare finish
  // that carries a stray byte.
  task automatic test_directed();
    send_word(OP_FINISH, 8'ha5);
    send_word(OP_ABSORB, 8'h61);
    send_word(OP_UNUSED, 8'hff);
    send_word(OP_ABSORB, 8'h62);
    send_word(OP_ABSORB_FINISH, 8'h63);
    send_word(OP_ABSORB_FINISH, 8'hff);
    send_word(OP_ABSORB, 8'h00);
    send_word(OP_FINISH, 8'hff);
    send_word(OP_ABSORB, 8'hff);
    send_word(OP_ABSORB, 8'h00);
    send_word(OP_UNUSED, 8'h00);
    send_word(OP_ABSORB, 8'h80);
    send_word(OP_FINISH, 8'h00);
    wait_drained();
  endtask

  // A length just past the one/two final block split and a full block that
  // ends on the finish word, back to back with no idling on either side.
  task automatic test_padding_edges();
    sender_gaps     = 1'b0;
    receiver_stalls = 1'b0;
    send_message(56, 1'b0, 1'b0);
    send_message(64, 1'b1, 1'b0);
    wait_drained();
    sender_gaps     = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  // Receiver holds off while the sender keeps offering the next message,
  // so the block sits on its digest and stalls intake.
  task automatic test_backpressure();
    send_message(3, 1'b1, 1'b0);
    hold_cycles = HOLD_CYCLES;
    send_message(6, 1'b0, 1'b0);
    send_message(1, 1'b1, 1'b0);
    wait_drained();
  endtask

  // Random short messages with a sprinkle of unused opcodes.
  task automatic test_random_messages();
    int unsigned len;
    int unsigned start_words;
    int unsigned start_digests;
    start_words   = words_sent;
    start_digests = digests_owed;
    while (words_sent - start_words < 20 || digests_owed - start_digests < 3) begin
      len = $urandom_range(15);
      send_message(len, 1'($urandom), 1'b1);
      // Now and then let everything drain before the next message.
      if ($urandom_range(9) == 0) wait_drained();
    end
    wait_drained();
  endtask

  initial begin
    hash_reset();
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_directed();
    test_padding_edges();
    test_backpressure();
    test_random_messages();

    // Anything the block emits after this point is unowed and gets flagged.
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("sha1_message_digest_test: PASS");
    end else begin
      $display("sha1_message_digest_test: FAIL");
    end
    $finish;
  end

  // Hang guard: far beyond the slowest correct run.
  initial begin
    #10_000_000;
    $display("sha1_message_digest_test: FAIL");
    $finish;
  end

endmodule
